[hw/rtl/phl_pkg.sv]
// Package for the polyline haversine length block: shared widths, constants,
// datapath operation codes, controller/datapath command and status structs.
// No dependencies.
package phl_pkg;

   localparam int PHL_CORDIC_ITERATIONS = 24;

   localparam int PHL_LAT_W = 31;
   localparam int PHL_LON_W = 32;
   localparam int PHL_SPD_W = 8;
   localparam int PHL_LEN_W = 32;
   localparam int PHL_WGT_W = 8;
   localparam int PHL_RAD_W = 23;

   localparam logic [PHL_RAD_W-1:0] PHL_RADIUS_RESET = 23'd6365000;

   // Last step indices of the square root and of the two divisions.
   localparam logic [5:0] PHL_SQRT_LAST = 6'd31;
   localparam logic [5:0] PHL_ADIV_LAST = 6'd34;
   localparam logic [5:0] PHL_WDIV_LAST = 6'd7;

   // Degree constants in units of 1e-7 degree.
   localparam logic [32:0] PHL_DEG_TURN2   = 33'd7200000000;
   localparam logic [32:0] PHL_DEG_TURN    = 33'd3600000000;
   localparam logic [32:0] PHL_DEG_HALF    = 33'd1800000000;
   localparam logic [32:0] PHL_DEG_QUARTER = 33'd900000000;

   // pi / 180 / 1e7 scaled by 2^54.
   localparam logic [24:0] PHL_RAD_SCALE = 25'd31441057;
   localparam logic [33:0] PHL_GAIN_INV  = 34'd652032874;
   localparam logic [30:0] PHL_HALF_PI   = 31'd1686629713;
   localparam logic [30:0] PHL_ONE_Q30   = 31'h4000_0000;

   typedef enum logic [4:0] {
      OP_NONE, OP_LOAD, OP_ABS, OP_MOD, OP_FOLD, OP_SCALE, OP_ZLOAD, OP_ROT,
      OP_COR1, OP_COR2, OP_COR3, OP_P1, OP_P2, OP_T1, OP_T2, OP_T3, OP_T4,
      OP_H, OP_SQLOAD, OP_SQ, OP_SQSTORE, OP_VLOAD, OP_VEC, OP_DPRE, OP_DIV,
      OP_THETA, OP_SEG1, OP_SEG2, OP_UPD, OP_WPRE, OP_EMIT
   } phl_op_type;

   typedef struct packed {
      phl_op_type op;
      logic [5:0] idx;
      logic [1:0] job;
   } phl_cmd_type;

   typedef struct packed {
      logic have_prev;
      logic last;
      logic out_free;
   } phl_status_type;

   // Arctangent of 2^-i in radians, Q30.
   function automatic logic [30:0] phl_atan(input logic [4:0] i);
      logic [30:0] r;
      case (i)
         5'd0:  r = 31'h3243F6A8;
         5'd1:  r = 31'h1DAC6705;
         5'd2:  r = 31'h0FADBAFC;
         5'd3:  r = 31'h07F56EA6;
         5'd4:  r = 31'h03FEAB76;
         5'd5:  r = 31'h01FFD55B;
         5'd6:  r = 31'h00FFFAAA;
         5'd7:  r = 31'h007FFF55;
         5'd8:  r = 31'h003FFFEA;
         5'd9:  r = 31'h001FFFFD;
         5'd10: r = 31'h000FFFFF;
         5'd11: r = 31'h0007FFFF;
         5'd12: r = 31'h0003FFFF;
         5'd13: r = 31'h0001FFFF;
         5'd14: r = 31'h0000FFFF;
         5'd15: r = 31'h00007FFF;
         5'd16: r = 31'h00003FFF;
         5'd17: r = 31'h00001FFF;
         5'd18: r = 31'h00000FFF;
         5'd19: r = 31'h000007FF;
         5'd20: r = 31'h000003FF;
         5'd21: r = 31'h000001FF;
         5'd22: r = 31'h000000FF;
         5'd23: r = 31'h0000007F;
         5'd24: r = 31'h0000003F;
         5'd25: r = 31'h0000001F;
         5'd26: r = 31'h0000000F;
         5'd27: r = 31'h00000008;
         5'd28: r = 31'h00000004;
         5'd29: r = 31'h00000002;
         5'd30: r = 31'h00000001;
         default: r = 31'h00000000;
      endcase
      return r;
   endfunction

endpackage

[hw/rtl/phl_channels.sv]
// Handshake channel interfaces of the polyline haversine length block.
// Depends on phl_pkg for the field widths.
interface phl_req_if;
   import phl_pkg::*;
   logic                        valid;
   logic                        ready;
   logic signed [PHL_LAT_W-1:0] latitude;
   logic signed [PHL_LON_W-1:0] longitude;
   logic [PHL_SPD_W-1:0]        speed_limit;
   logic                        last_point;
   modport source(output valid, latitude, longitude, speed_limit, last_point, input ready);
   modport sink(input valid, latitude, longitude, speed_limit, last_point, output ready);
endinterface

interface phl_rsp_if;
   import phl_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [PHL_LEN_W-1:0] total_length;
   logic [PHL_WGT_W-1:0] travel_weight;
   logic                 length_saturated;
   modport source(output valid, total_length, travel_weight, length_saturated, input ready);
   modport sink(input valid, total_length, travel_weight, length_saturated, output ready);
endinterface

interface phl_csr_if;
   import phl_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [PHL_RAD_W-1:0] earth_radius_m;
   modport source(output valid, earth_radius_m, input ready);
   modport sink(input valid, earth_radius_m, output ready);
endinterface

[hw/rtl/phl_ctrl.sv]
// Polyline haversine length sequencer: one-hot state machine issuing one
// datapath command per cycle unless idle or held at emit. Uses phl_pkg.
module phl_ctrl #(
   parameter int CORDIC_ITERATIONS = phl_pkg::PHL_CORDIC_ITERATIONS
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  phl_pkg::phl_status_type status,
   output phl_pkg::phl_cmd_type    cmd
);
   import phl_pkg::*;

   localparam logic [5:0] ROT_LAST = 6'(CORDIC_ITERATIONS - 1);

   typedef enum logic [30:0] {
      ST_IDLE    = 31'd1 << 0,
      ST_ABS     = 31'd1 << 1,
      ST_MOD     = 31'd1 << 2,
      ST_FOLD    = 31'd1 << 3,
      ST_SCALE   = 31'd1 << 4,
      ST_ZLOAD   = 31'd1 << 5,
      ST_ROT     = 31'd1 << 6,
      ST_COR1    = 31'd1 << 7,
      ST_COR2    = 31'd1 << 8,
      ST_COR3    = 31'd1 << 9,
      ST_P1      = 31'd1 << 10,
      ST_P2      = 31'd1 << 11,
      ST_T1      = 31'd1 << 12,
      ST_T2      = 31'd1 << 13,
      ST_T3      = 31'd1 << 14,
      ST_T4      = 31'd1 << 15,
      ST_H       = 31'd1 << 16,
      ST_SQLOAD  = 31'd1 << 17,
      ST_SQ      = 31'd1 << 18,
      ST_SQSTORE = 31'd1 << 19,
      ST_VLOAD   = 31'd1 << 20,
      ST_VEC     = 31'd1 << 21,
      ST_DPRE    = 31'd1 << 22,
      ST_DIV     = 31'd1 << 23,
      ST_THETA   = 31'd1 << 24,
      ST_SEG1    = 31'd1 << 25,
      ST_SEG2    = 31'd1 << 26,
      ST_UPD     = 31'd1 << 27,
      ST_WPRE    = 31'd1 << 28,
      ST_WDIV    = 31'd1 << 29,
      ST_EMIT    = 31'd1 << 30
   } phl_state_type;

   phl_state_type state_ff, state_in;
   logic [5:0]    cnt_ff, cnt_in;
   logic [1:0]    job_ff, job_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      job_in   = job_ff;
      cmd.op   = OP_NONE;
      cmd.idx  = cnt_ff;
      cmd.job  = job_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               job_in   = 2'd0;
               cnt_in   = 6'd0;
               state_in = status.have_prev ? ST_ABS : ST_UPD;
            end
         end
         ST_ABS: begin
            cmd.op   = OP_ABS;
            state_in = ST_MOD;
         end
         ST_MOD: begin
            cmd.op   = OP_MOD;
            state_in = ST_FOLD;
         end
         ST_FOLD: begin
            cmd.op   = OP_FOLD;
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            cmd.op   = OP_SCALE;
            state_in = ST_ZLOAD;
         end
         ST_ZLOAD: begin
            cmd.op   = OP_ZLOAD;
            state_in = ST_ROT;
         end
         ST_ROT: begin
            cmd.op = OP_ROT;
            if (cnt_ff == ROT_LAST) begin
               cnt_in   = 6'd0;
               state_in = ST_COR1;
            end else begin
               cnt_in = cnt_ff + 6'd1;
            end
         end
         ST_COR1: begin
            cmd.op   = OP_COR1;
            state_in = ST_COR2;
         end
         ST_COR2: begin
            cmd.op   = OP_COR2;
            state_in = ST_COR3;
         end
         ST_COR3: begin
            cmd.op = OP_COR3;
            if (job_ff == 2'd3) begin
               state_in = ST_P1;
            end else begin
               job_in   = job_ff + 2'd1;
               state_in = ST_ABS;
            end
         end
         ST_P1: begin
            cmd.op   = OP_P1;
            state_in = ST_P2;
         end
         ST_P2: begin
            cmd.op   = OP_P2;
            state_in = ST_T1;
         end
         ST_T1: begin
            cmd.op   = OP_T1;
            state_in = ST_T2;
         end
         ST_T2: begin
            cmd.op   = OP_T2;
            state_in = ST_T3;
         end
         ST_T3: begin
            cmd.op   = OP_T3;
            state_in = ST_T4;
         end
         ST_T4: begin
            cmd.op   = OP_T4;
            state_in = ST_H;
         end
         ST_H: begin
            cmd.op   = OP_H;
            job_in   = 2'd0;
            state_in = ST_SQLOAD;
         end
         ST_SQLOAD: begin
            cmd.op   = OP_SQLOAD;
            cnt_in   = 6'd0;
            state_in = ST_SQ;
         end
         ST_SQ: begin
            cmd.op = OP_SQ;
            if (cnt_ff == PHL_SQRT_LAST) begin
               cnt_in   = 6'd0;
               state_in = ST_SQSTORE;
            end else begin
               cnt_in = cnt_ff + 6'd1;
            end
         end
         ST_SQSTORE: begin
            cmd.op = OP_SQSTORE;
            if (job_ff == 2'd0) begin
               job_in   = 2'd1;
               state_in = ST_SQLOAD;
            end else begin
               state_in = ST_VLOAD;
            end
         end
         ST_VLOAD: begin
            cmd.op   = OP_VLOAD;
            cnt_in   = 6'd0;
            state_in = ST_VEC;
         end
         ST_VEC: begin
            cmd.op = OP_VEC;
            if (cnt_ff == ROT_LAST) begin
               cnt_in   = 6'd0;
               state_in = ST_DPRE;
            end else begin
               cnt_in = cnt_ff + 6'd1;
            end
         end
         ST_DPRE: begin
            cmd.op   = OP_DPRE;
            cnt_in   = 6'd0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.op = OP_DIV;
            if (cnt_ff == PHL_ADIV_LAST) begin
               cnt_in   = 6'd0;
               state_in = ST_THETA;
            end else begin
               cnt_in = cnt_ff + 6'd1;
            end
         end
         ST_THETA: begin
            cmd.op   = OP_THETA;
            state_in = ST_SEG1;
         end
         ST_SEG1: begin
            cmd.op   = OP_SEG1;
            state_in = ST_SEG2;
         end
         ST_SEG2: begin
            cmd.op   = OP_SEG2;
            state_in = ST_UPD;
         end
         ST_UPD: begin
            cmd.op   = OP_UPD;
            state_in = status.last ? ST_WPRE : ST_IDLE;
         end
         ST_WPRE: begin
            cmd.op   = OP_WPRE;
            cnt_in   = 6'd0;
            state_in = ST_WDIV;
         end
         ST_WDIV: begin
            cmd.op = OP_DIV;
            if (cnt_ff == PHL_WDIV_LAST) begin
               cnt_in   = 6'd0;
               state_in = ST_EMIT;
            end else begin
               cnt_in = cnt_ff + 6'd1;
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.op   = OP_EMIT;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= 6'd0;
         job_ff   <= 2'd0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         job_ff   <= job_in;
      end
   end

endmodule

[hw/rtl/phl_dp.sv]
// Datapath of the polyline haversine length block: shared multiplier, CORDIC
// stage, square root and divider steps, accumulator and result register.
// Depends on phl_pkg; driven by commands from phl_ctrl.
module phl_dp (
   input  logic                                 clock,
   input  logic                                 reset,
   input  phl_pkg::phl_cmd_type                 cmd,
   output phl_pkg::phl_status_type              status,
   input  logic signed [phl_pkg::PHL_LAT_W-1:0] req_latitude,
   input  logic signed [phl_pkg::PHL_LON_W-1:0] req_longitude,
   input  logic [phl_pkg::PHL_SPD_W-1:0]        req_speed_limit,
   input  logic                                 req_last_point,
   input  logic                                 csr_valid,
   input  logic [phl_pkg::PHL_RAD_W-1:0]        csr_earth_radius_m,
   input  logic                                 rsp_ready,
   output logic                                 rsp_valid,
   output logic [phl_pkg::PHL_LEN_W-1:0]        rsp_total_length,
   output logic [phl_pkg::PHL_WGT_W-1:0]        rsp_travel_weight,
   output logic                                 rsp_length_saturated
);
   import phl_pkg::*;

   // Input item and polyline state.
   logic signed [31:0] cur_lat_ff, cur_lon_ff, prev_lat_ff, prev_lon_ff;
   logic [7:0]         speed_ff;
   logic               last_ff, have_prev_ff;
   logic [39:0]        acc_ff;
   logic [22:0]        radius_ff;

   // Angle reduction and CORDIC.
   logic [32:0]        red_ff;
   logic [30:0]        ang_ff;
   logic [1:0]         neg_ff;
   logic signed [33:0] x_ff, y_ff;
   logic signed [32:0] z_ff;
   logic signed [40:0] xn_ff;
   logic [30:0]        sa_ff, sb_ff, c1_ff, c2_ff, w_ff, t_ff, u_ff, theta_ff;
   logic [60:0]        term_ff, h_ff;
   logic [62:0]        sqv_ff, sqr_ff;

   // Divider.
   logic [32:0]        rem_ff, dvs_ff;
   logic [34:0]        dlo_ff, q_ff;
   logic               dsat_ff, yneg_ff, xpos_ff;

   // Shared multiplier.
   logic signed [34:0] mul_a, mul_b;
   logic signed [69:0] prod_in, prod_ff;

   logic               rsp_valid_ff;
   logic [31:0]        rsp_len_ff;
   logic [7:0]         rsp_wgt_ff;
   logic               rsp_sat_ff;

   function automatic logic [30:0] clamp_q30(input logic signed [40:0] v);
      logic [30:0] r;
      if (v < 0) r = 31'd0;
      else if (v > $signed({10'd0, PHL_ONE_Q30})) r = PHL_ONE_Q30;
      else r = v[30:0];
      return r;
   endfunction

   // Combinational helpers.
   logic [4:0]         sh;
   logic signed [33:0] xs, ys;
   logic signed [32:0] at;
   logic               sigma;
   logic signed [32:0] dsrc;
   logic [32:0]        red_abs, red_mod;
   logic [32:0]        f1, f2;
   logic               fneg;
   logic signed [40:0] corr, yn;
   logic signed [62:0] hv;
   logic [60:0]        h_cl;
   logic [5:0]         sqsh;
   logic [62:0]        sqbit, sqtrial;
   logic [33:0]        mag;
   logic [33:0]        r2;
   logic               ge;
   logic signed [36:0] tv;
   logic [30:0]        th;
   logic [55:0]        segsum;
   logic [40:0]        accsum;
   logic [43:0]        wdvd;
   logic [13:0]        wdvr;
   logic               lsat;

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.op)
         OP_SCALE: begin
            mul_a = {4'd0, ang_ff};
            mul_b = {10'd0, PHL_RAD_SCALE};
         end
         OP_COR1: begin
            mul_a = {y_ff[33], y_ff};
            mul_b = {{2{z_ff[32]}}, z_ff};
         end
         OP_COR2: begin
            mul_a = {x_ff[33], x_ff};
            mul_b = {{2{z_ff[32]}}, z_ff};
         end
         OP_P1: begin
            mul_a = {4'd0, c1_ff};
            mul_b = {4'd0, c2_ff};
         end
         OP_T1, OP_T3: begin
            mul_a = {4'd0, w_ff};
            mul_b = {4'd0, sb_ff};
         end
         OP_T4: begin
            mul_a = {4'd0, sa_ff};
            mul_b = {4'd0, sa_ff};
         end
         OP_SEG1: begin
            mul_a = {12'd0, radius_ff};
            mul_b = {4'd0, theta_ff};
         end
         default: begin
            mul_a = '0;
         end
      endcase
   end

   assign prod_in = mul_a * mul_b;

   // CORDIC micro-rotation, shared by rotation and vectoring.
   always_comb begin
      sh    = cmd.idx[4:0];
      xs    = x_ff >>> sh;
      ys    = y_ff >>> sh;
      at    = {2'd0, phl_atan(sh)};
      sigma = (cmd.op == OP_VEC) ? (y_ff <= 0) : !z_ff[32];
   end

   // Angle reduction.
   always_comb begin
      case (cmd.job)
         2'd0: dsrc = {cur_lat_ff[31], cur_lat_ff} - {prev_lat_ff[31], prev_lat_ff};
         2'd1: dsrc = {cur_lon_ff[31], cur_lon_ff} - {prev_lon_ff[31], prev_lon_ff};
         2'd2: dsrc = {prev_lat_ff[31], prev_lat_ff};
         default: dsrc = {cur_lat_ff[31], cur_lat_ff};
      endcase
      red_abs = dsrc[32] ? 33'(-dsrc) : 33'(dsrc);
      if (red_ff >= PHL_DEG_TURN2) red_mod = red_ff - PHL_DEG_TURN2;
      else if (red_ff >= PHL_DEG_TURN) red_mod = red_ff - PHL_DEG_TURN;
      else red_mod = red_ff;
      f1   = (red_ff > PHL_DEG_HALF) ? (PHL_DEG_TURN - red_ff) : red_ff;
      fneg = cmd.job[1] && (f1 > PHL_DEG_QUARTER);
      f2   = fneg ? (PHL_DEG_HALF - f1) : f1;
   end

   // Correction terms, haversine sum and square root step.
   always_comb begin
      corr    = {prod_ff[69], prod_ff[69:30]};
      yn      = {{7{y_ff[33]}}, y_ff} + corr;
      if (neg_ff[0] != neg_ff[1]) hv = {2'd0, prod_ff[60:0]} - {2'd0, term_ff};
      else hv = {2'd0, prod_ff[60:0]} + {2'd0, term_ff};
      if (hv < 0) h_cl = 61'd0;
      else if (hv > $signed(63'd1 << 60)) h_cl = 61'd1 << 60;
      else h_cl = hv[60:0];
      sqsh    = 6'd62 - {cmd.idx[4:0], 1'b0};
      sqbit   = 63'd1 << sqsh;
      sqtrial = sqr_ff + sqbit;
   end

   // Divider step, final angle and accumulation.
   always_comb begin
      mag = y_ff[33] ? 34'(-y_ff) : 34'(y_ff);
      r2  = {rem_ff, dlo_ff[34]};
      ge  = (r2 >= {1'b0, dvs_ff});
      if (!xpos_ff) tv = {{4{z_ff[32]}}, z_ff};
      else if (dsat_ff) tv = yneg_ff ? -37'sd1 : $signed({6'd0, PHL_HALF_PI}) + 37'sd1;
      else if (yneg_ff) tv = {{4{z_ff[32]}}, z_ff} - {2'd0, q_ff};
      else tv = {{4{z_ff[32]}}, z_ff} + {2'd0, q_ff};
      if (tv < 0) th = 31'd0;
      else if (tv > $signed({6'd0, PHL_HALF_PI})) th = PHL_HALF_PI;
      else th = tv[30:0];
      segsum = prod_ff[55:0] + (56'd1 << 24);
      accsum = {1'b0, acc_ff} + {10'd0, segsum[55:25]};
      wdvd   = {1'b0, acc_ff, 3'd0} + {4'd0, acc_ff};
      wdvr   = {1'b0, speed_ff, 5'd0} + {3'd0, speed_ff, 3'd0};
      lsat   = |acc_ff[39:32];
   end

   // Registers with reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         have_prev_ff <= 1'b0;
         acc_ff       <= 40'd0;
         radius_ff    <= PHL_RADIUS_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            radius_ff <= csr_earth_radius_m;
         end
         if (cmd.op == OP_SEG2) begin
            acc_ff <= accsum[40] ? {40{1'b1}} : accsum[39:0];
         end
         if (cmd.op == OP_UPD) begin
            have_prev_ff <= 1'b1;
         end
         if (cmd.op == OP_EMIT) begin
            have_prev_ff <= 1'b0;
            acc_ff       <= 40'd0;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      case (cmd.op)
         OP_LOAD: begin
            cur_lat_ff <= {req_latitude[30], req_latitude};
            cur_lon_ff <= req_longitude;
            speed_ff   <= req_speed_limit;
            last_ff    <= req_last_point;
         end
         OP_ABS: begin
            red_ff <= red_abs;
         end
         OP_MOD: begin
            red_ff <= red_mod;
         end
         OP_FOLD: begin
            ang_ff <= f2[30:0];
            if (cmd.job == 2'd2) neg_ff[0] <= fneg;
            if (cmd.job == 2'd3) neg_ff[1] <= fneg;
         end
         OP_ZLOAD: begin
            z_ff <= cmd.job[1] ? prod_ff[56:24] : prod_ff[57:25];
            x_ff <= PHL_GAIN_INV;
            y_ff <= '0;
         end
         OP_ROT, OP_VEC: begin
            if (sigma) begin
               x_ff <= x_ff - ys;
               y_ff <= y_ff + xs;
               z_ff <= z_ff - at;
            end else begin
               x_ff <= x_ff + ys;
               y_ff <= y_ff - xs;
               z_ff <= z_ff + at;
            end
         end
         OP_COR2: begin
            xn_ff <= {{7{x_ff[33]}}, x_ff} - corr;
         end
         OP_COR3: begin
            case (cmd.job)
               2'd0: sa_ff <= clamp_q30(yn);
               2'd1: sb_ff <= clamp_q30(yn);
               2'd2: c1_ff <= clamp_q30(xn_ff);
               default: c2_ff <= clamp_q30(xn_ff);
            endcase
         end
         OP_P2, OP_T2: begin
            w_ff <= prod_ff[60:30];
         end
         OP_T4: begin
            term_ff <= prod_ff[60:0];
         end
         OP_H: begin
            h_ff <= h_cl;
         end
         OP_SQLOAD: begin
            sqv_ff <= (cmd.job == 2'd0) ? {2'd0, h_ff} : (63'd1 << 60) - {2'd0, h_ff};
            sqr_ff <= '0;
         end
         OP_SQ: begin
            if (sqv_ff >= sqtrial) begin
               sqv_ff <= sqv_ff - sqtrial;
               sqr_ff <= (sqr_ff >> 1) + sqbit;
            end else begin
               sqr_ff <= sqr_ff >> 1;
            end
         end
         OP_SQSTORE: begin
            if (cmd.job == 2'd0) t_ff <= sqr_ff[30:0];
            else u_ff <= sqr_ff[30:0];
         end
         OP_VLOAD: begin
            x_ff <= {3'd0, u_ff};
            y_ff <= {3'd0, t_ff};
            z_ff <= '0;
         end
         OP_DPRE: begin
            xpos_ff <= (x_ff > 0);
            yneg_ff <= y_ff[33];
            dsat_ff <= ({6'd0, mag} >= {1'b0, x_ff, 5'd0});
            rem_ff  <= {4'd0, mag[33:5]};
            dlo_ff  <= {mag[4:0], 30'd0};
            dvs_ff  <= x_ff[32:0];
            q_ff    <= '0;
         end
         OP_DIV: begin
            rem_ff <= ge ? 33'(r2 - {1'b0, dvs_ff}) : r2[32:0];
            dlo_ff <= {dlo_ff[33:0], 1'b0};
            q_ff   <= {q_ff[33:0], ge};
         end
         OP_THETA: begin
            theta_ff <= th;
         end
         OP_UPD: begin
            prev_lat_ff <= cur_lat_ff;
            prev_lon_ff <= cur_lon_ff;
         end
         OP_WPRE: begin
            dsat_ff <= (speed_ff == 8'd0) || (wdvd[43:8] >= {22'd0, wdvr});
            rem_ff  <= wdvd[40:8];
            dlo_ff  <= {wdvd[7:0], 27'd0};
            dvs_ff  <= {19'd0, wdvr};
            q_ff    <= '0;
         end
         OP_EMIT: begin
            rsp_len_ff <= lsat ? {32{1'b1}} : acc_ff[31:0];
            rsp_wgt_ff <= dsat_ff ? 8'd255 : q_ff[7:0];
            rsp_sat_ff <= lsat || dsat_ff;
         end
         default: begin
            red_ff <= red_ff;
         end
      endcase
   end

   assign status.have_prev = have_prev_ff;
   assign status.last      = last_ff;
   assign status.out_free  = !rsp_valid_ff || rsp_ready;

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_total_length     = rsp_len_ff;
   assign rsp_travel_weight    = rsp_wgt_ff;
   assign rsp_length_saturated = rsp_sat_ff;

endmodule

[hw/rtl/polyline_haversine_length.sv]
// A point with no stored predecessor is only loaded and stored; any other point
// also passes through the shared CORDIC stage, the 32-step square root run twice
// and the 35-step divider.
// A last point adds the weight division and the result load.
// Throughput: one item at a time; the result register lets the next item start.
// Reset (synchronous, active high) clears the polyline and restores the radius.
module polyline_haversine_length #(
   parameter int CORDIC_ITERATIONS = phl_pkg::PHL_CORDIC_ITERATIONS
) (
   input logic   clock,
   input logic   reset,
   phl_req_if.sink   req,
   phl_rsp_if.source rsp,
   phl_csr_if.sink   csr
);
   import phl_pkg::*;

   // The controller walks each segment through four rotations (two half-angle
   // sines, two cosines), the haversine product chain, two square roots, one
   // vectoring pass with a residual division, and the radius multiply.
   phl_cmd_type    cmd;
   phl_status_type status;
   logic           req_ready;

   phl_ctrl #(
      .CORDIC_ITERATIONS(CORDIC_ITERATIONS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // The datapath holds the stored point, the length accumulator, the radius
   // register and the output register that holds a finished item.
   phl_dp u_dp (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .status               (status),
      .req_latitude         (req.latitude),
      .req_longitude        (req.longitude),
      .req_speed_limit      (req.speed_limit),
      .req_last_point       (req.last_point),
      .csr_valid            (csr.valid),
      .csr_earth_radius_m   (csr.earth_radius_m),
      .rsp_ready            (rsp.ready),
      .rsp_valid            (rsp.valid),
      .rsp_total_length     (rsp.total_length),
      .rsp_travel_weight    (rsp.travel_weight),
      .rsp_length_saturated (rsp.length_saturated)
   );

   assign req.ready = req_ready;
   // The radius register takes a write in any cycle.
   assign csr.ready = 1'b1;

   // After an item is accepted the sequencer is busy in the following cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready) |=> !req.ready)
      else $error("input ready stayed high after an accepted item");

   // A result only appears while the sequencer was busy finishing a polyline.
   a_result_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp.valid) |-> !$past(req.ready))
      else $error("result appeared while the sequencer was idle");

endmodule
